[src/tstme_pkg.sv]
// Shared types and constants for the time-sorted table with min-size eviction.
// Holds the request and result beat structs, controller states and the
// command/status structs between the controller and the datapath. No dependencies.
package tstme_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int TS_W      = 32;
	localparam int SZ_W      = 32;
	localparam int LIMIT_W   = 36;
	localparam int OUT_TOT_W = 36;
	localparam int OUT_CNT_W = 5;

	localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 36'd32000000;
	localparam logic [OUT_TOT_W-1:0] TOTAL_MAX   = '1;

	// Request type codes.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_BACKUP = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_EVICTED  = 2'd2,
		ST_DONE     = 2'd3
	} status_t;

	typedef struct packed {
		logic            req_type;
		logic [TS_W-1:0] new_timestamp;
		logic [SZ_W-1:0] new_size;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [TS_W-1:0]      evicted_timestamp;
		logic [SZ_W-1:0]      evicted_size;
		logic [OUT_TOT_W-1:0] total_after;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHECK,
		S_INS_SCAN,
		S_INS_WRITE,
		S_INS_DONE,
		S_EV_CHECK,
		S_EV_SCAN,
		S_EV_REMOVE,
		S_EV_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_req;
		logic    idx_clr;
		logic    idx_one;
		logic    idx_inc;
		logic    best_init;
		logic    scan_min;
		logic    ins_write;
		logic    ev_remove;
		logic    emit;
		status_t emit_status;
		logic    emit_last;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic head_first;
		logic scan_end;
		logic ts_stop;
		logic over_limit;
	} dp_stat_t;

endpackage

[src/tstme_dp.sv]
// Datapath of the time-sorted table: entry registers, count, running total,
// size limit, scan index, minimum tracker and the result register.
// Depends on tstme_pkg.
module tstme_dp #(
	parameter int TABLE_DEPTH = tstme_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tstme_pkg::req_t                   req,
	input  logic                              cfg_we,
	input  logic [tstme_pkg::LIMIT_W-1:0]     cfg_data,
	input  tstme_pkg::ctrl_cmd_t              cmd,
	output tstme_pkg::dp_stat_t               stat,
	output logic                              result_valid,
	output tstme_pkg::result_t                result
);
	import tstme_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TOT_W = (TS_W + CNT_W > OUT_TOT_W) ? (SZ_W + CNT_W) : OUT_TOT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [TS_W-1:0]    ts_q [TABLE_DEPTH];
	logic [SZ_W-1:0]    sz_q [TABLE_DEPTH];
	logic [TS_W-1:0]    req_ts_q;
	logic [SZ_W-1:0]    req_sz_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOT_W-1:0]   total_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   best_idx_q;
	logic [TS_W-1:0]    best_ts_q;
	logic [SZ_W-1:0]    best_sz_q;
	logic               res_valid_q;
	result_t            res_q;
	logic [TS_W-1:0]    rd_ts;
	logic [SZ_W-1:0]    rd_sz;

	// One read port at the scan index.
	assign rd_ts = ts_q[idx_q[IDX_W-1:0]];
	assign rd_sz = sz_q[idx_q[IDX_W-1:0]];

	// Status toward the controller.
	assign stat.full       = (count_q == DEPTH_C);
	assign stat.empty      = (count_q == '0);
	assign stat.head_first = (count_q == '0) || (req_ts_q < ts_q[0]);
	assign stat.scan_end   = (idx_q >= count_q);
	assign stat.ts_stop    = !(req_ts_q > rd_ts);
	assign stat.over_limit = (total_q > TOT_W'(limit_q));

	// Latch the request fields when a beat is taken.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_ts_q <= req.new_timestamp;
			req_sz_q <= req.new_size;
		end
	end

	// Entry registers: shift up to open a slot on insert, shift down to close
	// the slot of an evicted entry.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_entry
		localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);
		logic [TS_W-1:0] prev_ts, next_ts;
		logic [SZ_W-1:0] prev_sz, next_sz;
		logic            has_next;

		if (i > 0) begin : g_prev
			assign prev_ts = ts_q[i-1];
			assign prev_sz = sz_q[i-1];
		end else begin : g_noprev
			assign prev_ts = req_ts_q;
			assign prev_sz = req_sz_q;
		end

		if (i < TABLE_DEPTH - 1) begin : g_next
			assign next_ts  = ts_q[i+1];
			assign next_sz  = sz_q[i+1];
			assign has_next = 1'b1;
		end else begin : g_nonext
			assign next_ts  = ts_q[i];
			assign next_sz  = sz_q[i];
			assign has_next = 1'b0;
		end

		always_ff @(posedge clk) begin
			if (cmd.ins_write) begin
				if (SLOT == idx_q) begin
					ts_q[i] <= req_ts_q;
					sz_q[i] <= req_sz_q;
				end else if (SLOT > idx_q) begin
					ts_q[i] <= prev_ts;
					sz_q[i] <= prev_sz;
				end
			end else if (cmd.ev_remove && has_next && SLOT >= best_idx_q) begin
				ts_q[i] <= next_ts;
				sz_q[i] <= next_sz;
			end
		end
	end

	// Count, running total, size limit and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			limit_q <= LIMIT_RESET;
			idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.ins_write) begin
				count_q <= CNT_W'(count_q + 1'b1);
				total_q <= TOT_W'(total_q + TOT_W'(req_sz_q));
			end else if (cmd.ev_remove) begin
				count_q <= CNT_W'(count_q - 1'b1);
				total_q <= TOT_W'(total_q - TOT_W'(best_sz_q));
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_one) begin
				idx_q <= CNT_W'(1);
			end else if (cmd.idx_inc) begin
				idx_q <= CNT_W'(idx_q + 1'b1);
			end
		end
	end

	// Minimum tracker; the first smallest size in table order wins.
	always_ff @(posedge clk) begin
		if (cmd.best_init) begin
			best_idx_q <= '0;
			best_ts_q  <= ts_q[0];
			best_sz_q  <= sz_q[0];
		end else if (cmd.scan_min && (rd_sz < best_sz_q)) begin
			best_idx_q <= idx_q;
			best_ts_q  <= rd_ts;
			best_sz_q  <= rd_sz;
		end
	end

	// Result register and its strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.status <= cmd.emit_status;
			if (cmd.emit_status == ST_EVICTED) begin
				res_q.evicted_timestamp <= best_ts_q;
				res_q.evicted_size      <= best_sz_q;
			end else begin
				res_q.evicted_timestamp <= '0;
				res_q.evicted_size      <= '0;
			end
			if (total_q > TOT_W'(TOTAL_MAX)) begin
				res_q.total_after <= TOTAL_MAX;
			end else begin
				res_q.total_after <= total_q[OUT_TOT_W-1:0];
			end
			res_q.entry_count <= OUT_CNT_W'(count_q);
			res_q.last        <= cmd.emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count exceeds table depth");

	// An insert write only happens with a free slot, at or below the count.
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> (count_q < DEPTH_C) && (idx_q <= count_q))
		else $error("insert write into a full table or past the end");

	// A removal always targets a stored entry.
	a_rm_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_remove |-> (count_q != '0) && (best_idx_q < count_q))
		else $error("eviction of an entry that is not stored");

	// A removal lowers the total by exactly the victim size.
	a_rm_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_remove |=> total_q == TOT_W'($past(total_q) - TOT_W'($past(best_sz_q))))
		else $error("running total not reduced by the evicted size");

endmodule

[src/tstme_ctrl.sv]
// Controller state machine of the time-sorted table: sequences the insert
// scan and write, and the eviction scan, removal and result beats.
// Depends on tstme_pkg.
module tstme_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 req_type,
	input  tstme_pkg::dp_stat_t  stat,
	output tstme_pkg::ctrl_cmd_t cmd,
	output logic                 busy
);
	import tstme_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					if (req_type == REQ_INSERT) begin
						state_d = S_INS_CHECK;
					end else begin
						state_d = S_EV_CHECK;
					end
				end
			end
			S_INS_CHECK: begin
				if (stat.full) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_REJECTED;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.head_first) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_INS_WRITE;
				end else begin
					cmd.idx_one = 1'b1;
					state_d     = S_INS_SCAN;
				end
			end
			S_INS_SCAN: begin
				// Walk past every entry strictly earlier than the new one.
				if (stat.scan_end || stat.ts_stop) begin
					state_d = S_INS_WRITE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_INS_WRITE: begin
				cmd.ins_write = 1'b1;
				state_d       = S_INS_DONE;
			end
			S_INS_DONE: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_INSERTED;
				cmd.emit_last   = 1'b1;
				state_d         = S_IDLE;
			end
			S_EV_CHECK: begin
				if (stat.over_limit && !stat.empty) begin
					cmd.best_init = 1'b1;
					cmd.idx_one   = 1'b1;
					state_d       = S_EV_SCAN;
				end else begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_DONE;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EV_SCAN: begin
				if (stat.scan_end) begin
					state_d = S_EV_REMOVE;
				end else begin
					cmd.scan_min = 1'b1;
					cmd.idx_inc  = 1'b1;
				end
			end
			S_EV_REMOVE: begin
				cmd.ev_remove = 1'b1;
				state_d       = S_EV_EMIT;
			end
			S_EV_EMIT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_EVICTED;
				state_d         = S_EV_CHECK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// A taken request always leaves the idle state.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but controller stayed idle");

	// Only one table update is commanded in a cycle.
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_write && cmd.ev_remove))
		else $error("insert and removal commanded together");

	// The last beat of a request returns the controller to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> !busy)
		else $error("controller busy after the final result");

endmodule

[src/time_sorted_table_min_size_evict_core.sv]
// Top level of the time-sorted table with min-size eviction.
// Instantiates tstme_ctrl and tstme_dp; depends on tstme_pkg.
//
// Usage:
//   A request beat (req) is taken at a rising edge with start high and busy
//   low. An insert (req_type 0) places the entry in timestamp order and gives
//   one result beat; into a full table it gives one rejected beat instead.
//   A backup (req_type 1) evicts the smallest-size entry (first in order on
//   ties) while the total exceeds the size limit, one evicted beat per entry,
//   then one done beat. The final beat of a request carries last.
//   Each result beat holds one cycle, marked by result_valid; the receiver cannot stall it.
//   The size limit is written on the cfg channel (cfg_valid, cfg_ready,
//   cfg_data); cfg_ready is high whenever busy is low.
// Sequencing:
//   Insert: an entry that goes first is written without a scan, else the
//   entries after the head are scanned past every one earlier than it; a
//   rejected insert gives its beat from the check state. Backup: each eviction
//   runs a one-entry-per-cycle minimum scan, a removal and an evicted beat.
//   busy stays high until the final beat has been issued.
// Reset: the table empties, the total clears and the limit returns to 32000000.
module time_sorted_table_min_size_evict_core #(
	parameter int TABLE_DEPTH = tstme_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tstme_pkg::req_t               req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tstme_pkg::LIMIT_W-1:0] cfg_data,
	output logic                          result_valid,
	output tstme_pkg::result_t            result
);
	import tstme_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      busy_w;

	// The limit is only taken between requests.
	assign cfg_ready = !busy_w;
	assign busy      = busy_w;

	tstme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy_w)
	);

	tstme_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cfg_we       (cfg_valid && !busy_w),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[dv/testbench.sv]
// Self-checking testbench for time_sorted_table_min_size_evict_core: directed and random
// insert/backup requests checked beat by beat against an in-bench table model.
// Depends on tstme_pkg and the core RTL.
import tstme_pkg::*;

// Scoreboard: mirrors the sorted table and queues the result beats each request must produce.
class sorted_table_scoreboard;
	logic [TS_W-1:0]    ts_col[TABLE_DEPTH_DEF];
	logic [SZ_W-1:0]    sz_col[TABLE_DEPTH_DEF];
	int unsigned        fill;
	logic [63:0]        total;
	logic [LIMIT_W-1:0] limit;
	result_t            pending_results[$];
	int                 errors;
	int                 n_requests;
	int                 n_evicted;
	int                 n_rejected;

	function new();
		fill       = 0;
		total      = '0;
		limit      = LIMIT_RESET;
		errors     = 0;
		n_requests = 0;
		n_evicted  = 0;
		n_rejected = 0;
	endfunction

	function void set_limit(logic [LIMIT_W-1:0] value);
		limit = value;
	endfunction

	// Build one result beat from the current total and count.
	function void queue_beat(status_t st, logic [TS_W-1:0] ts, logic [SZ_W-1:0] sz,
		logic is_last);
		result_t r;
		r.status            = st;
		r.evicted_timestamp = ts;
		r.evicted_size      = sz;
		r.total_after       = (total > {28'd0, TOTAL_MAX}) ? TOTAL_MAX : total[OUT_TOT_W-1:0];
		r.entry_count       = fill[OUT_CNT_W-1:0];
		r.last              = is_last;
		pending_results.push_back(r);
	endfunction

	// Apply one accepted request to the table and queue its beats.
	function void take_request(req_t q);
		int unsigned     pos;
		int unsigned     best;
		logic [TS_W-1:0] vts;
		logic [SZ_W-1:0] vsz;
		n_requests++;
		if (q.req_type == REQ_INSERT) begin
			if (fill >= TABLE_DEPTH_DEF) begin
				n_rejected++;
				queue_beat(ST_REJECTED, '0, '0, 1'b1);
				return;
			end
			// A tie with the head goes after it; a tie with a later entry goes ahead of it.
			if (fill == 0 || q.new_timestamp < ts_col[0]) begin
				pos = 0;
			end else begin
				pos = 1;
				while (pos < fill && q.new_timestamp > ts_col[pos])
					pos++;
			end
			for (int unsigned i = fill; i > pos; i--) begin
				ts_col[i] = ts_col[i-1];
				sz_col[i] = sz_col[i-1];
			end
			ts_col[pos] = q.new_timestamp;
			sz_col[pos] = q.new_size;
			fill++;
			total += q.new_size;
			queue_beat(ST_INSERTED, '0, '0, 1'b1);
		end else begin
			// Evict the smallest size, earliest in order on ties, until under budget.
			while (total > limit && fill > 0) begin
				best = 0;
				for (int unsigned i = 1; i < fill; i++)
					if (sz_col[i] < sz_col[best])
						best = i;
				vts = ts_col[best];
				vsz = sz_col[best];
				for (int unsigned i = best; i + 1 < fill; i++) begin
					ts_col[i] = ts_col[i+1];
					sz_col[i] = sz_col[i+1];
				end
				fill--;
				total -= vsz;
				n_evicted++;
				queue_beat(ST_EVICTED, vts, vsz, 1'b0);
			end
			queue_beat(ST_DONE, '0, '0, 1'b1);
		end
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Check one observed result beat against the oldest queued one.
	function void match_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result beat with nothing pending: status %0d", got.status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("status", 64'(want.status), 64'(got.status));
		compare_field("evicted_timestamp", 64'(want.evicted_timestamp),
			64'(got.evicted_timestamp));
		compare_field("evicted_size", 64'(want.evicted_size), 64'(got.evicted_size));
		compare_field("total_after", 64'(want.total_after), 64'(got.total_after));
		compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
		compare_field("last", 64'(want.last), 64'(got.last));
	endfunction
endclass

module testbench;
	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               req;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;
	logic               result_valid;
	result_t            result;

	sorted_table_scoreboard sb = new();
	int                     limit_writes = 0;
	bit                     no_idle = 1'b0;

	always #5 clk = ~clk;

	time_sorted_table_min_size_evict_core #(
		.TABLE_DEPTH(TABLE_DEPTH_DEF)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	// Every result beat lasts one cycle and is taken at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.match_result(result);
	end

	// Random gap after an accepted request, with occasional back-to-back stretches.
	task automatic idle_after();
		int gap;
		if ($urandom_range(0, 9) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_request(req_t r);
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		sb.take_request(r);
		idle_after();
	endtask

	task automatic send_insert(logic [TS_W-1:0] ts, logic [SZ_W-1:0] sz);
		req_t r;
		r.req_type      = REQ_INSERT;
		r.new_timestamp = ts;
		r.new_size      = sz;
		send_request(r);
	endtask

	// The entry fields are don't-care on a backup, so they carry noise.
	task automatic send_backup();
		req_t r;
		r.req_type      = REQ_BACKUP;
		r.new_timestamp = $urandom();
		r.new_size      = $urandom();
		send_request(r);
	endtask

	// Stop issuing and wait for every pending beat.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_limit(value);
		limit_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Small ranges give frequent timestamp ties; one case covers the full field and one picks its extremes.
	function automatic logic [TS_W-1:0] pick_timestamp();
		case ($urandom_range(0, 3))
			0, 1:    return TS_W'($urandom_range(0, 15));
			2:       return TS_W'($urandom());
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	// A scale of zero means the full 32-bit size range.
	function automatic logic [SZ_W-1:0] pick_size(int unsigned scale);
		if (scale == 0)
			return SZ_W'($urandom());
		return SZ_W'($urandom_range(0, scale));
	endfunction

	initial begin
		logic [LIMIT_W-1:0] lim;
		int unsigned        scale;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty backup, head placement and ties, extremes, full table.
		send_backup();
		send_insert(32'd1000, 32'd5);
		send_insert(32'd500, 32'd7);
		send_insert(32'd500, 32'd5);
		send_insert(32'd1000, 32'd9);
		send_insert(32'd0, 32'd0);
		send_insert('1, '1);
		for (int k = 0; k < 10; k++)
			send_insert(TS_W'($urandom_range(0, 2000)), SZ_W'($urandom_range(1, 50)));
		send_insert(32'd3, 32'd3);
		send_backup();

		// Zero budget: a zero total evicts nothing, any size above zero empties the table.
		write_limit('0);
		send_insert(32'd7, 32'd0);
		send_insert(32'd3, 32'd0);
		send_backup();
		send_insert(32'd5, 32'd1);
		send_backup();

		// Largest budget: nothing is ever evicted.
		write_limit('1);
		send_insert('1, '1);
		send_insert('0, '1);
		send_backup();

		// Random phases, each with its own budget and size scale.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					lim   = {4'($urandom_range(0, 15)), 32'($urandom())};
					scale = 0;
				end
				1: begin
					lim   = LIMIT_W'($urandom_range(0, 2000));
					scale = 400;
				end
				2: begin
					lim   = '0;
					scale = 300;
				end
				3: begin
					lim   = '1;
					scale = 0;
				end
				default: begin
					lim   = LIMIT_W'($urandom_range(1000, 20000));
					scale = 3000;
				end
			endcase
			write_limit(lim);
			repeat (15) begin
				if ($urandom_range(0, 9) < 7)
					send_insert(pick_timestamp(), pick_size(scale));
				else
					send_backup();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Ran %0d requests under %0d size-limit settings.", sb.n_requests,
			limit_writes + 1);
		$display("Saw %0d evictions and %0d inserts refused on a full table.", sb.n_evicted,
			sb.n_rejected);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
